FILE: hdl/sync_word_frame_deframer_macros.svh
// assertion macros for the sync word frame deframer
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef SYNC_WORD_FRAME_DEFRAMER_MACROS_SVH
`define SYNC_WORD_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SWFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SWFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/swfd_pkg.sv
// shared widths for the sync word frame deframer
// no dependencies; used by the top level and the word ram
package swfd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned WORD_IDX_W  = 4;
  localparam int unsigned ERR_W       = 16;
  // output beat: index, value, error count, padded to whole bytes
  localparam int unsigned OUT_BITS    = WORD_IDX_W + WORD_W + ERR_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

FILE: hdl/swfd_word_ram.sv
// payload word store: one write port, one read port with registered data
// depends on swfd_pkg for the word width
module swfd_word_ram #(
  parameter int unsigned DEPTH  = 12,
  parameter int unsigned ADDR_W = 4
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [swfd_pkg::WORD_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [swfd_pkg::WORD_W-1:0] rdata_o
);

  logic [swfd_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [swfd_pkg::WORD_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/sync_word_frame_deframer.sv
// sync word frame deframer top level: header search, frame tracking, word run output
// depends on swfd_pkg, swfd_word_ram and sync_word_frame_deframer_macros.svh
//
// Usage:
//   s_axis carries received serial bytes, one byte per beat in tdata[7:0].
//   Every byte is shifted into a 16-bit header register (earlier byte high) and
//   compared with header_word, written through cfg_we_i / cfg_wdata_i. A match
//   opens a frame; the next 2*NUM_WORDS bytes are packed into little-endian
//   words and written into a word ram, one write per byte pair.
//   When the last payload byte arrives the frame is sent on m_axis as a run of
//   NUM_WORDS beats, tlast on the final one. A header inside an open frame
//   restarts it and bumps a wrapping resync error count.
// Flow control:
//   A byte that does not close a frame leaves s_axis ready. A closing byte is
//   followed by a run of NUM_WORDS ram reads, each followed by one output
//   beat that is held while m_axis stalls; s_axis tready stays low
//   for the whole run. The single read port of the word ram sets the pace of the run.
// Reset:
//   rst_ni clears header register, header_word, frame state and error count.
//   The word ram needs no clearing: only words written in the same frame are read.
//   A stalled m_axis beat holds its data until taken.
`include "sync_word_frame_deframer_macros.svh"

module sync_word_frame_deframer #(
  parameter int unsigned NUM_WORDS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: header_word
  input  logic                                cfg_we_i,
  input  logic [swfd_pkg::WORD_W-1:0]         cfg_wdata_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [swfd_pkg::BYTE_W-1:0]         s_axis_tdata,   // [7:0] rx_byte
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [3:0] word_index, [19:4] word_value, [35:20] resync_errors, [39:36] zero
  output logic [swfd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast    // last_word
);

  localparam int unsigned ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);
  localparam int unsigned PAD_W = swfd_pkg::OUT_TDATA_W - swfd_pkg::OUT_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  logic [swfd_pkg::WORD_W-1:0] hdr_word_q;
  logic [swfd_pkg::WORD_W-1:0] hdr_q, hdr_d;
  logic                        in_frame_q, in_frame_d;
  logic [ADDR_W-1:0]           word_q, word_d;
  logic                        half_q, half_d;
  logic [swfd_pkg::BYTE_W-1:0] lo_q;
  logic [swfd_pkg::ERR_W-1:0]  err_q, err_d;
  logic [1:0]                  state_q, state_d;
  logic [ADDR_W-1:0]           rd_idx_q, rd_idx_d;

  logic                        in_fire;
  logic                        out_fire;
  logic                        last_byte;
  logic                        complete;
  logic                        match;
  logic                        ram_we;
  logic [swfd_pkg::WORD_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [swfd_pkg::WORD_W-1:0] ram_rdata;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  // header search and frame position
  assign hdr_d     = {hdr_q[swfd_pkg::BYTE_W-1:0], s_axis_tdata};
  assign last_byte = in_frame_q && half_q && (word_q == LAST_WORD);
  assign complete  = in_fire && last_byte;
  assign match     = (hdr_d == hdr_word_q);

  always_comb begin
    in_frame_d = in_frame_q;
    word_d     = word_q;
    half_d     = half_q;
    err_d      = err_q;
    if (in_fire) begin
      if (in_frame_q) begin
        if (last_byte) begin
          in_frame_d = 1'b0;
        end else begin
          half_d = ~half_q;
          if (half_q) begin
            word_d = word_q + 1'b1;
          end
        end
      end
      // header test runs after the byte is stored
      if (match) begin
        if (in_frame_q && !last_byte) begin
          err_d = err_q + 1'b1;
        end
        in_frame_d = 1'b1;
        word_d     = '0;
        half_d     = 1'b0;
      end
    end
  end

  // word write on the high byte, low byte held until then
  assign ram_we    = in_fire && in_frame_q && half_q;
  assign ram_wdata = {s_axis_tdata, lo_q};

  always_ff @(posedge clk_i) begin
    if (in_fire && in_frame_q && !half_q) begin
      lo_q <= s_axis_tdata;
    end
  end

  // output run sequencer
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (complete) begin
          state_d  = ST_READ;
          rd_idx_d = '0;
        end
      end
      ST_READ: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_fire) begin
          if (rd_idx_q == LAST_WORD) begin
            state_d = ST_IDLE;
          end else begin
            state_d  = ST_READ;
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ram_re = (state_q == ST_READ);

  swfd_word_ram #(
    .DEPTH  (NUM_WORDS),
    .ADDR_W (ADDR_W)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_word_q <= '0;
      hdr_q      <= '0;
      in_frame_q <= 1'b0;
      word_q     <= '0;
      half_q     <= 1'b0;
      err_q      <= '0;
      state_q    <= ST_IDLE;
      rd_idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        hdr_word_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        hdr_q <= hdr_d;
      end
      in_frame_q <= in_frame_d;
      word_q     <= word_d;
      half_q     <= half_d;
      err_q      <= err_d;
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
    end
  end

  // output beat
  assign m_axis_tvalid = (state_q == ST_SHOW);
  assign m_axis_tlast  = (rd_idx_q == LAST_WORD);
  assign m_axis_tdata  = {{PAD_W{1'b0}}, err_q, ram_rdata,
                          swfd_pkg::WORD_IDX_W'(rd_idx_q)};

  // checks
  `SWFD_ASSERT_NOW(a_no_overlap, 1'b1, !(s_axis_tready && m_axis_tvalid),
    "input taken while a word beat is shown")
  `SWFD_ASSERT_NEXT(a_run_ends_idle, out_fire && m_axis_tlast, s_axis_tready,
    "input not reopened after the last word")
  `SWFD_ASSERT_NEXT(a_index_steps, out_fire && !m_axis_tlast,
    rd_idx_q == ADDR_W'($past(rd_idx_q) + 1'b1), "word index did not advance by one")
  `SWFD_ASSERT_NOW(a_pos_in_range, in_frame_q, word_q <= LAST_WORD,
    "frame position beyond the last word")

endmodule
